FILE: design/assert_macros.svh
// Assertion helpers used by the checker in fss_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

FILE: design/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fss_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int MAX_TEXT    = 1024;

	localparam int BYTE_W  = 8;
	localparam int FUNC_W  = 2;
	localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int POS_W   = $clog2(MAX_TEXT + 1);
	localparam int INDEX_W = 10;
	localparam int OUT_W   = 16;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_START   = 2'd0,
		FUNC_PATTERN = 2'd1,
		FUNC_TEXT    = 2'd2,
		FUNC_END     = 2'd3
	} func_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic text_shift;
		logic pat_shift;
		logic pat_clear;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/fss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fss_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire fss_pkg::cell_ctrl_t ctrl,
	input  wire fss_pkg::byte_t      text_in,
	input  wire fss_pkg::byte_t      pat_in,
	input  wire                 valid_in,
	output fss_pkg::byte_t      text_out,
	output fss_pkg::byte_t      pat_out,
	output logic                valid_out,
	output logic                ok
);

	fss_pkg::byte_t text_q;
	fss_pkg::byte_t pat_q;
	logic           valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q <= '0;
		end else if (ctrl.text_shift) begin
			text_q <= text_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pat_shift) begin
			pat_q <= pat_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pat_clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.pat_shift) begin
			valid_q <= valid_in;
		end
	end

	// Compare the byte this cell will hold after the shift with its pattern byte.
	assign ok        = !valid_q || (text_in == pat_q);
	assign text_out  = text_q;
	assign pat_out   = pat_q;
	assign valid_out = valid_q;

endmodule
`default_nettype wire

FILE: design/first_substring_search_unit.sv
// Channel | Dir | tdata (low bit up)                    | tuser       | tlast
// s_      | in  | data_byte[7:0]                        | func[1:0]   | -
// m_      | out | found[0], match_index[10:1], 0[15:11]  | -           | -
//
// A word that completes a match or ends the text, while no verdict is out yet, loads
// the output register in that same cycle, set by the single compare across the
// 32-cell chain. s_tready drops only while a result waits and m_tready is low.
// Reset clears the text window, chain valid bits, counters and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module first_substring_search_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [fss_pkg::BYTE_W-1:0]   s_tdata,  // data_byte[7:0]
	input  wire  [fss_pkg::FUNC_W-1:0]   s_tuser,  // func[1:0]
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [fss_pkg::OUT_W-1:0]    m_tdata   // found[0], match_index[10:1]
);

	localparam int PAD_W = fss_pkg::OUT_W - 1 - fss_pkg::INDEX_W;

	fss_pkg::func_t     func;
	fss_pkg::cell_ctrl_t ctrl;
	logic               accept;
	logic               pat_full;
	logic               text_ok;
	logic               all_ok;
	logic               hit_text;
	logic               end_emit;
	logic               emit;
	logic               found_d;
	logic [fss_pkg::INDEX_W-1:0] idx_d;
	logic [fss_pkg::POS_W-1:0]   pos_next;
	logic [fss_pkg::POS_W-1:0]   len_ext;
	logic [fss_pkg::POS_W-1:0]   pos_diff;

	logic [fss_pkg::LEN_W-1:0]   len_q;
	logic [fss_pkg::POS_W-1:0]   pos_q;
	logic                        given_q;
	logic                        out_valid_q;
	logic                        found_q;
	logic [fss_pkg::INDEX_W-1:0] idx_q;

	fss_pkg::byte_t text_chain [0:fss_pkg::MAX_PATTERN];
	fss_pkg::byte_t pat_chain  [0:fss_pkg::MAX_PATTERN];
	logic [fss_pkg::MAX_PATTERN:0]   valid_chain;
	logic [fss_pkg::MAX_PATTERN-1:0] cell_ok;

	assign func     = fss_pkg::func_t'(s_tuser);
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pat_full = (len_q == fss_pkg::LEN_W'(fss_pkg::MAX_PATTERN));
	assign text_ok  = accept && (func == fss_pkg::FUNC_TEXT) && !given_q
		&& (pos_q < fss_pkg::POS_W'(fss_pkg::MAX_TEXT));

	always_comb begin
		ctrl.text_shift = text_ok;
		ctrl.pat_shift  = accept && (func == fss_pkg::FUNC_PATTERN) && !pat_full;
		ctrl.pat_clear  = accept && (func == fss_pkg::FUNC_START);
	end

	assign text_chain[0]  = s_tdata;
	assign pat_chain[0]   = s_tdata;
	assign valid_chain[0] = 1'b1;

	genvar g;
	generate
		for (g = 0; g < fss_pkg::MAX_PATTERN; g++) begin : g_cell
			fss_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.text_in   (text_chain[g]),
				.pat_in    (pat_chain[g]),
				.valid_in  (valid_chain[g]),
				.text_out  (text_chain[g+1]),
				.pat_out   (pat_chain[g+1]),
				.valid_out (valid_chain[g+1]),
				.ok        (cell_ok[g])
			);
		end
	endgenerate

	assign all_ok   = &cell_ok;
	assign pos_next = pos_q + fss_pkg::POS_W'(1);
	assign len_ext  = {{(fss_pkg::POS_W - fss_pkg::LEN_W){1'b0}}, len_q};
	assign pos_diff = pos_next - len_ext;

	always_comb begin
		hit_text = text_ok && ((len_q == '0) || ((pos_next >= len_ext) && all_ok));
		end_emit = accept && (func == fss_pkg::FUNC_END) && !given_q;
		emit     = hit_text || end_emit;
		found_d  = hit_text || (len_q == '0);
		idx_d    = (hit_text && (len_q != '0)) ? pos_diff[fss_pkg::INDEX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pos_q   <= '0;
			given_q <= 1'b0;
		end else begin
			if (ctrl.pat_clear) begin
				len_q   <= '0;
				pos_q   <= '0;
				given_q <= 1'b0;
			end else begin
				if (ctrl.pat_shift) begin
					len_q <= len_q + fss_pkg::LEN_W'(1);
				end
				if (text_ok) begin
					pos_q <= pos_next;
				end
				if (emit) begin
					given_q <= 1'b1;
				end
			end
		end
	end

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q <= found_d;
			idx_q   <= idx_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, idx_q, found_q};

endmodule
`default_nettype wire

FILE: design/fss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fss_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire [fss_pkg::BYTE_W-1:0]  s_tdata,
	input wire [fss_pkg::FUNC_W-1:0]  s_tuser,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [fss_pkg::OUT_W-1:0]   m_tdata
);

	logic s_word;
	logic stall;
	logic in_known;

	assign s_word   = s_tvalid && s_tready;
	assign stall    = m_tvalid && !m_tready;
	assign in_known = (s_tdata == s_tdata) && (s_tuser == s_tuser);

	`ASSERT_NEXT(a_hold_valid, clk, arst_n, stall, m_tvalid)
	`ASSERT_NEXT(a_hold_data, clk, arst_n, stall, $stable(m_tdata))
	`ASSERT_IMPLIES(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[15:11] == 5'd0)
	`ASSERT_IMPLIES(a_miss_index, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[10:1] == 10'd0)
	`ASSERT_IMPLIES(a_cause, clk, arst_n, $rose(m_tvalid), $past(s_word) && $past(in_known))

endmodule

bind first_substring_search_unit fss_checker u_fss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: tb/first_substring_search_unit_test.sv
`timescale 1ns / 1ps
module first_substring_search_unit_test;
	import fss_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 10;
	localparam int PHASE_WORDS = 175;

	typedef struct {
		func_t func;
		byte_t data;
	} search_word_t;

	typedef struct {
		bit               found;
		logic [INDEX_W-1:0] index;
	} verdict_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	wire                 s_tready;
	logic [BYTE_W-1:0]   s_tdata = '0;
	logic [FUNC_W-1:0]   s_tuser = FUNC_START;
	wire                 m_tvalid;
	logic                m_tready = 1'b0;
	wire  [OUT_W-1:0]    m_tdata;

	first_substring_search_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	search_word_t queued_words[$];
	verdict_t     pending_verdicts[$];
	search_word_t next_word;
	verdict_t     got_verdict;
	verdict_t     want_verdict;

	int sender_idle_pct = 0;
	int sink_stall_pct = 0;
	int error_count = 0;
	int idle_cycles = 0;

	// Mirror of the search state.
	byte_t pat_mem [MAX_PATTERN];
	byte_t text_win [MAX_PATTERN];
	int    pat_len = 0;
	int    text_pos = 0;
	bit    verdict_given = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic post_verdict(input bit found, input int index);
		verdict_t v;
		v.found = found;
		v.index = index[INDEX_W-1:0];
		pending_verdicts.push_back(v);
		verdict_given = 1'b1;
	endtask

	task automatic search_step(input func_t f, input byte_t b);
		int  first;
		bit  hit;
		case (f)
			FUNC_START: begin
				pat_len = 0;
				text_pos = 0;
				verdict_given = 1'b0;
			end
			FUNC_PATTERN: begin
				if (pat_len < MAX_PATTERN) begin
					pat_mem[pat_len] = b;
					pat_len++;
				end
			end
			FUNC_END: begin
				if (!verdict_given)
					post_verdict(pat_len == 0, 0);
			end
			default: begin
				// Drop text once a verdict is out or the position has saturated.
				if (!verdict_given && text_pos < MAX_TEXT) begin
					text_win[text_pos % MAX_PATTERN] = b;
					text_pos++;
					if (pat_len == 0) begin
						post_verdict(1'b1, 0);
					end else if (text_pos >= pat_len) begin
						first = text_pos - pat_len;
						hit = 1'b1;
						for (int j = 0; j < pat_len; j++)
							if (text_win[(first + j) % MAX_PATTERN] != pat_mem[j])
								hit = 1'b0;
						if (hit)
							post_verdict(1'b1, first);
					end
				end
			end
		endcase
	endtask

	// Driver: hold the word until taken, then maybe idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FUNC_START;
		end else begin
			if (s_tvalid && s_tready)
				search_step(func_t'(s_tuser), s_tdata);
			if (!s_tvalid || s_tready) begin
				if (queued_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_word = queued_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_word.data;
					s_tuser <= next_word.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result word against the oldest expected verdict.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_verdict.found = m_tdata[0];
				got_verdict.index = m_tdata[INDEX_W:1];
				if (pending_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected result found=%0d index=%0d",
						got_verdict.found, got_verdict.index));
				end else begin
					want_verdict = pending_verdicts.pop_front();
					if (got_verdict.found != want_verdict.found)
						report_mismatch($sformatf("found %0d, expected %0d",
							got_verdict.found, want_verdict.found));
					if (got_verdict.index != want_verdict.index)
						report_mismatch($sformatf("match_index %0d, expected %0d",
							got_verdict.index, want_verdict.index));
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("first_substring_search_unit_test: done, errors");
				$finish;
			end
		end
	end

	task automatic push_word(input func_t f, input byte_t b);
		search_word_t w;
		w.func = f;
		w.data = b;
		queued_words.push_back(w);
	endtask

	// One job with random content over a two-symbol alphabet, or a burst of noise.
	task automatic add_random_job(inout int count);
		byte_t sym0;
		byte_t sym1;
		int    plen;
		int    tlen;
		int    pick;
		bit    wide;
		sym0 = byte_t'($urandom);
		sym1 = sym0 ^ byte_t'($urandom_range(1, 255));
		pick = $urandom_range(19);
		if (pick == 0) begin
			tlen = $urandom_range(1, 4);
			for (int k = 0; k < tlen; k++)
				push_word(func_t'($urandom_range(3)), byte_t'($urandom));
			count += tlen;
			return;
		end
		wide = (pick == 1 || pick == 2);
		push_word(FUNC_START, byte_t'($urandom));
		count++;
		if (wide) begin
			// Fill the store, then overflow it with bytes that must be dropped.
			for (int k = 0; k < MAX_PATTERN; k++)
				push_word(FUNC_PATTERN, sym0);
			plen = $urandom_range(1, 2);
			for (int k = 0; k < plen; k++)
				push_word(FUNC_PATTERN, sym1);
			count += MAX_PATTERN + plen;
			tlen = $urandom_range(30, 45);
		end else begin
			plen = (pick == 3) ? 0 : $urandom_range(1, 4);
			for (int k = 0; k < plen; k++)
				push_word(FUNC_PATTERN, $urandom_range(1) ? sym1 : sym0);
			count += plen;
			tlen = $urandom_range(0, 24);
		end
		for (int k = 0; k < tlen; k++) begin
			if (!wide && $urandom_range(19) == 0)
				push_word(FUNC_PATTERN, $urandom_range(1) ? sym1 : sym0);
			else if (wide)
				push_word(FUNC_TEXT, ($urandom_range(15) == 0) ? sym1 : sym0);
			else
				push_word(FUNC_TEXT, $urandom_range(1) ? sym1 : sym0);
		end
		count += tlen;
		if ($urandom_range(7) != 0) begin
			push_word(FUNC_END, byte_t'($urandom));
			count++;
		end
	endtask

	task automatic wait_drained();
		while (queued_words.size() != 0 || s_tvalid || pending_verdicts.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct);
		int count;
		count = 0;
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		while (count < PHASE_WORDS)
			add_random_job(count);
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// End of text straight after reset: empty pattern matches at zero.
		push_word(FUNC_END, 8'h00);
		push_word(FUNC_TEXT, 8'h41);
		// Empty pattern, first text byte.
		push_word(FUNC_START, 8'hFF);
		push_word(FUNC_TEXT, 8'h00);
		// Pattern longer than the text.
		push_word(FUNC_START, 8'h00);
		push_word(FUNC_PATTERN, 8'hFF);
		push_word(FUNC_PATTERN, 8'h00);
		push_word(FUNC_TEXT, 8'hFF);
		push_word(FUNC_END, 8'hFF);
		push_word(FUNC_END, 8'h00);
		// Plain match, then words after the verdict.
		push_word(FUNC_START, 8'h00);
		push_word(FUNC_PATTERN, 8'h5A);
		push_word(FUNC_PATTERN, 8'hA5);
		push_word(FUNC_TEXT, 8'h5A);
		push_word(FUNC_TEXT, 8'h5A);
		push_word(FUNC_TEXT, 8'hA5);
		push_word(FUNC_TEXT, 8'h5A);
		push_word(FUNC_END, 8'h00);
		// Pattern grows while text streams.
		push_word(FUNC_START, 8'h00);
		push_word(FUNC_PATTERN, 8'h11);
		push_word(FUNC_TEXT, 8'h22);
		push_word(FUNC_PATTERN, 8'h33);
		push_word(FUNC_TEXT, 8'h11);
		push_word(FUNC_TEXT, 8'h33);
		push_word(FUNC_END, 8'h00);

		// Match completed by the last storable text byte: index 1020.
		push_word(FUNC_START, 8'h00);
		push_word(FUNC_PATTERN, 8'hC3);
		push_word(FUNC_PATTERN, 8'h3C);
		push_word(FUNC_PATTERN, 8'hF0);
		push_word(FUNC_PATTERN, 8'h0F);
		for (int k = 0; k < MAX_TEXT - 4; k++)
			push_word(FUNC_TEXT, byte_t'($urandom_range(0, 7)));
		push_word(FUNC_TEXT, 8'hC3);
		push_word(FUNC_TEXT, 8'h3C);
		push_word(FUNC_TEXT, 8'hF0);
		push_word(FUNC_TEXT, 8'h0F);
		push_word(FUNC_TEXT, 8'h00);
		push_word(FUNC_END, 8'h00);

		// Saturate the position; a would-be match past saturation must be dropped.
		push_word(FUNC_START, 8'h00);
		push_word(FUNC_PATTERN, 8'hFF);
		for (int k = 0; k < MAX_TEXT; k++)
			push_word(FUNC_TEXT, byte_t'($urandom_range(0, 254)));
		push_word(FUNC_TEXT, 8'hFF);
		push_word(FUNC_TEXT, 8'hFF);
		push_word(FUNC_END, 8'h00);
		wait_drained();

		run_random_phase(62, 0);
		run_random_phase(0, 62);
		run_random_phase(28, 28);
		run_random_phase(0, 0);

		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("first_substring_search_unit_test: done, clean");
		else
			$display("first_substring_search_unit_test: done, errors");
		$finish;
	end

endmodule
